// ===== rtl/rfc_pkg.sv =====
// Shared types and constants for the response frame checker.
`default_nettype none

package rfc_pkg;

  // One received byte together with the length of its read window.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] window_length;
  } in_t;

  // One result: a payload byte or the final verdict of a window.
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] data_byte;
    logic [5:0] data_index;
    logic [2:0] status;
    logic [6:0] payload_length;
  } out_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_LCHK = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CSUM = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  // Verdict status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_WINDOW = 3'd1;
  localparam logic [2:0] ST_NO_START   = 3'd2;
  localparam logic [2:0] ST_BAD_LCHK   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;
  localparam logic [2:0] ST_NO_MARK    = 3'd5;
  localparam logic [2:0] ST_BAD_CSUM   = 3'd6;

  // Frame constants.
  localparam logic [7:0] MIN_FRAME  = 8'd5;
  localparam logic [7:0] START_LAST = 8'd4;
  localparam logic [8:0] LEN_TOTAL  = 9'h100;
  localparam logic [7:0] HOST_MARK  = 8'hD5;
  localparam logic [7:0] START_HI   = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/response_frame_checker.sv =====
// Response frame checker: start code hunt, length, marker and checksum checks.
//
// Usage: the input channel carries one received byte per beat, with the
// length of its read window (sampled on the first byte of each window).
// The result channel carries each payload byte as it arrives, then exactly
// one verdict per window: ok with the payload length, or an error status.
// Bytes after the verdict are dropped until the window ends; the next
// byte then opens a new window.
// Results: a result is registered into out_* from the accepted byte that causes it, or
// into the skid stage while out_* waits. Throughput: one byte per cycle while in_stall is low,
// set by the single state update of the parser, which needs only a compare and an 8-bit add.
// Stalling: the output register is backed by a one-entry skid stage, so a
// byte is still taken in the cycle the receiver first stalls; in_stall rises
// only once the skid stage holds a beat, and falls as soon as it drains.
// Reset: synchronous, active low; the parser returns to the start of a
// window hunting for the start code, and no result is pending.
`default_nettype none

module response_frame_checker #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rfc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rfc_pkg::out_t      out_data
);

  // Parser state.
  rfc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] ws_r, ws_nxt;
  logic       pz_r, pz_nxt;
  logic [7:0] start_r, start_nxt;
  logic [7:0] lf_r, lf_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic [7:0] sum_r, sum_nxt;

  // Output register and skid stage.
  logic          out_valid_r, skid_valid_r;
  rfc_pkg::out_t out_r, skid_r;

  logic          acc, take, gen;
  rfc_pkg::out_t res;

  // Window-start view of the state.
  logic            first;
  logic [7:0]      ws_cur;
  rfc_pkg::phase_t ph_cur;
  logic            pz_cur;
  logic [7:0]      pc_cur;
  logic [7:0]      sum_cur;
  logic [7:0]      ws_m4;
  logic [7:0]      rx;
  logic [7:0]      pc_inc;
  logic [8:0]      pos_inc;
  logic [9:0]      frame_end;

  assign acc  = in_valid && !in_stall;
  assign take = out_valid_r && !out_stall;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rx      = in_data.rx_byte;
  assign first   = (pos_r == 8'd0);
  assign ws_cur  = first ? in_data.window_length : ws_r;
  assign ph_cur  = first ? rfc_pkg::PH_HUNT : phase_r;
  assign pz_cur  = first ? 1'b0 : pz_r;
  assign pc_cur  = first ? 8'd0 : pc_r;
  assign sum_cur = first ? 8'd0 : sum_r;
  assign ws_m4   = ws_cur - rfc_pkg::START_LAST;
  assign pc_inc  = pc_cur + 8'd1;
  assign pos_inc = {1'b0, pos_r} + 9'd1;
  assign frame_end = {2'b00, start_r} + {2'b00, rfc_pkg::MIN_FRAME} + {2'b00, lf_r};

  // Parser step for one accepted byte.
  always_comb begin
    phase_nxt = ph_cur;
    ws_nxt    = ws_cur;
    pz_nxt    = pz_cur;
    start_nxt = start_r;
    lf_nxt    = lf_r;
    pc_nxt    = pc_cur;
    sum_nxt   = sum_cur;
    gen       = 1'b0;
    res       = '0;

    if (first && ((ws_cur < rfc_pkg::MIN_FRAME) ||
                  ({1'b0, ws_cur} > 9'(BUFFER_BYTES)))) begin
      gen = 1'b1;
      res.is_verdict = 1'b1;
      res.status = rfc_pkg::ST_BAD_WINDOW;
      phase_nxt = rfc_pkg::PH_DONE;
    end else begin
      case (ph_cur)
        rfc_pkg::PH_HUNT: begin
          if (pz_cur && (rx == rfc_pkg::START_HI) && (pos_r <= ws_m4)) begin
            start_nxt = pos_r - 8'd1;
            sum_nxt   = rfc_pkg::START_HI;
            phase_nxt = rfc_pkg::PH_LEN;
          end else begin
            pz_nxt = (rx == 8'd0);
            if (pos_r >= ws_m4) begin
              gen = 1'b1;
              res.is_verdict = 1'b1;
              res.status = rfc_pkg::ST_NO_START;
              phase_nxt = rfc_pkg::PH_DONE;
            end
          end
        end
        rfc_pkg::PH_LEN: begin
          lf_nxt    = rx;
          sum_nxt   = sum_cur + rx;
          phase_nxt = rfc_pkg::PH_LCHK;
        end
        rfc_pkg::PH_LCHK: begin
          if (({1'b0, lf_r} + {1'b0, rx}) != rfc_pkg::LEN_TOTAL) begin
            gen = 1'b1;
            res.is_verdict = 1'b1;
            res.status = rfc_pkg::ST_BAD_LCHK;
            phase_nxt = rfc_pkg::PH_DONE;
          end else if ({2'b00, ws_cur} < frame_end) begin
            gen = 1'b1;
            res.is_verdict = 1'b1;
            res.status = rfc_pkg::ST_TOO_LONG;
            phase_nxt = rfc_pkg::PH_DONE;
          end else begin
            sum_nxt   = sum_cur + rx;
            pc_nxt    = 8'd0;
            phase_nxt = rfc_pkg::PH_DATA;
          end
        end
        rfc_pkg::PH_DATA: begin
          if ((pc_cur == 8'd0) && (rx != rfc_pkg::HOST_MARK)) begin
            gen = 1'b1;
            res.is_verdict = 1'b1;
            res.status = rfc_pkg::ST_NO_MARK;
            phase_nxt = rfc_pkg::PH_DONE;
          end else begin
            gen = 1'b1;
            res.data_byte  = rx;
            res.data_index = pc_cur[5:0];
            sum_nxt = sum_cur + rx;
            pc_nxt  = pc_inc;
            if (pc_inc == lf_r) begin
              phase_nxt = rfc_pkg::PH_CSUM;
            end
          end
        end
        rfc_pkg::PH_CSUM: begin
          gen = 1'b1;
          res.is_verdict = 1'b1;
          if (sum_cur == ~rx) begin
            res.status = rfc_pkg::ST_OK;
            res.payload_length = lf_r[6:0];
          end else begin
            res.status = rfc_pkg::ST_BAD_CSUM;
          end
          phase_nxt = rfc_pkg::PH_DONE;
        end
        rfc_pkg::PH_DONE: begin
          gen = 1'b0;
        end
        default: begin
          phase_nxt = rfc_pkg::PH_DONE;
        end
      endcase
    end

    // Window position wraps at the end of the window.
    if (pos_inc >= {1'b0, ws_cur}) begin
      pos_nxt = 8'd0;
    end else begin
      pos_nxt = pos_inc[7:0];
    end
  end

  // Parser control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfc_pkg::PH_HUNT;
      pos_r   <= 8'd0;
      ws_r    <= 8'd0;
      pz_r    <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ws_r    <= ws_nxt;
      pz_r    <= pz_nxt;
    end
  end

  // Parser payload state.
  always_ff @(posedge clk) begin
    if (acc) begin
      start_r <= start_nxt;
      lf_r    <= lf_nxt;
      pc_r    <= pc_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Output register with skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (acc && gen) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output beat data.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (acc && gen) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // The skid stage only fills behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  // A verdict ends the frame: the parser sits in its done phase afterwards.
  a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && gen && res.is_verdict) |=> (phase_r == rfc_pkg::PH_DONE))
    else $error("parser left the done phase after a verdict");

  // Nothing is produced between the verdict and the end of the window.
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (phase_r == rfc_pkg::PH_DONE) && (pos_r != 8'd0)) |-> !gen)
    else $error("result produced after the verdict of a window");

  // The window position always stays inside the current window.
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 8'd0) |-> (pos_r < ws_r))
    else $error("window position ran past the window length");

endmodule

`default_nettype wire
